// File: design/assert_macros.svh
// Assertion macros shared by the codec RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define B40_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that one condition implies another on every clock edge outside reset.
`define B40_ASSERT_IMP(lbl, ante, cons, msg) \
  `B40_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: design/b40cc_pkg.sv
// Types, constants and symbol tables for the base-40 callsign codec.
package b40cc_pkg;

  localparam int unsigned NUM_BITS   = 48;
  localparam int unsigned MAX_DIGITS = 9;
  localparam int unsigned DIG_W      = 6;
  localparam int unsigned CHAR_W     = 8;

  localparam logic [DIG_W-1:0]    HALF_BASE  = 6'd20;
  localparam logic [NUM_BITS-1:0] CODE_LIMIT = 48'hEE6B27FFFFFF;

  localparam logic [CHAR_W-1:0] ASCII_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] ASCII_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] ASCII_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] ASCII_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_AT    = 8'h40;

  localparam logic [DIG_W-1:0] DIG_SPACE  = 6'd0;
  localparam logic [DIG_W-1:0] DIG_ZERO   = 6'd27;
  localparam logic [DIG_W-1:0] DIG_DASH   = 6'd37;
  localparam logic [DIG_W-1:0] DIG_SLASH  = 6'd38;
  localparam logic [DIG_W-1:0] DIG_DOT    = 6'd39;

  typedef enum logic {
    KIND_ENCODE = 1'b0,
    KIND_DECODE = 1'b1
  } b40cc_kind_e;

  typedef struct packed {
    b40cc_kind_e kind;
    logic        ovf;
    logic        hi;
  } b40cc_ctl_t;

  function automatic logic [DIG_W-1:0] b40_digit(input logic [CHAR_W-1:0] ch);
    logic [DIG_W-1:0] d;
    d = DIG_SPACE;
    case (ch) inside
      [8'h41:8'h5A]: d = DIG_W'(ch - ASCII_AT);
      [8'h30:8'h39]: d = DIG_W'(ch - ASCII_ZERO) + DIG_ZERO;
      ASCII_DASH:    d = DIG_DASH;
      ASCII_SLASH:   d = DIG_SLASH;
      ASCII_DOT:     d = DIG_DOT;
      default:       d = DIG_SPACE;
    endcase
    return d;
  endfunction

  function automatic logic [CHAR_W-1:0] b40_ascii(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    ch = ASCII_NUL;
    case (d) inside
      DIG_SPACE:    ch = ASCII_SPACE;
      [6'd1:6'd26]: ch = ASCII_AT + CHAR_W'(d);
      [6'd27:6'd36]: ch = ASCII_ZERO + CHAR_W'(d - DIG_ZERO);
      DIG_DASH:     ch = ASCII_DASH;
      DIG_SLASH:    ch = ASCII_SLASH;
      DIG_DOT:      ch = ASCII_DOT;
      default:      ch = ASCII_NUL;
    endcase
    return ch;
  endfunction

endpackage

// File: design/b40cc_cell.sv
// One conversion cell: a single binary/base-40 shift step with its pipeline register.
module b40cc_cell import b40cc_pkg::*; #(
  parameter int unsigned NDIG = 9
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  b40cc_ctl_t                     ctl_i,
  input  logic [NDIG-1:0][DIG_W-1:0]     dig_i,
  input  logic [NUM_BITS-1:0]            bin_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output b40cc_ctl_t                     ctl_o,
  output logic [NDIG-1:0][DIG_W-1:0]     dig_o,
  output logic [NUM_BITS-1:0]            bin_o
);

  logic                        valid_q;
  b40cc_ctl_t                  ctl_q, ctl_d;
  logic [NDIG-1:0][DIG_W-1:0]  dig_q, dig_d;
  logic [NUM_BITS-1:0]         bin_q, bin_d;
  logic [NDIG:0]               odd;
  logic [NDIG:0]               carry;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    logic [DIG_W-1:0] low;
    low      = DIG_SPACE;
    ctl_d    = ctl_i;
    carry[0] = bin_i[NUM_BITS-1];
    odd[NDIG] = 1'b0;
    for (int k = 0; k < NDIG; k++) begin
      odd[k] = dig_i[k][0];
    end
    for (int k = 0; k < NDIG; k++) begin
      carry[k+1] = (dig_i[k] >= HALF_BASE);
    end
    if (ctl_i.kind == KIND_DECODE) begin
      // double the digit vector and shift in the next code bit
      for (int k = 0; k < NDIG; k++) begin
        low      = carry[k+1] ? (dig_i[k] - HALF_BASE) : dig_i[k];
        dig_d[k] = {low[DIG_W-2:0], carry[k]};
      end
      bin_d    = {bin_i[NUM_BITS-2:0], 1'b0};
      ctl_d.hi = ctl_i.hi | carry[NDIG];
    end else begin
      // halve the digit vector and shift its low bit into the code
      for (int k = 0; k < NDIG; k++) begin
        dig_d[k] = {1'b0, dig_i[k][DIG_W-1:1]} + (odd[k+1] ? HALF_BASE : DIG_SPACE);
      end
      bin_d = {odd[0], bin_i[NUM_BITS-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ctl_q <= ctl_d;
      dig_q <= dig_d;
      bin_q <= bin_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign dig_o   = dig_q;
  assign bin_o   = bin_q;

endmodule

// File: design/base40_callsign_codec_unit.sv
// Datapath: 48 shift cells plus the output register, from input beat to output valid.
// Throughput: one beat per cycle unless the output stalls; one cell per code bit, 48 in all.
// A stalled output fills empty cells first, so input beats are taken until every cell is full.
// Reset clears all valid flags; payload registers are not reset.
// Encode halves the base-40 digits into the code; decode doubles code bits into digits.
module base40_callsign_codec_unit import b40cc_pkg::*; #(
  parameter int unsigned MAX_CHARS = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic [NUM_BITS-1:0] code_in_i,
  input  logic [CHAR_W-1:0]   char_0_i,
  input  logic [CHAR_W-1:0]   char_1_i,
  input  logic [CHAR_W-1:0]   char_2_i,
  input  logic [CHAR_W-1:0]   char_3_i,
  input  logic [CHAR_W-1:0]   char_4_i,
  input  logic [CHAR_W-1:0]   char_5_i,
  input  logic [CHAR_W-1:0]   char_6_i,
  input  logic [CHAR_W-1:0]   char_7_i,
  input  logic [CHAR_W-1:0]   char_8_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [NUM_BITS-1:0] code_out_o,
  output logic                status_o,
  output logic [CHAR_W-1:0]   out_0_o,
  output logic [CHAR_W-1:0]   out_1_o,
  output logic [CHAR_W-1:0]   out_2_o,
  output logic [CHAR_W-1:0]   out_3_o,
  output logic [CHAR_W-1:0]   out_4_o,
  output logic [CHAR_W-1:0]   out_5_o,
  output logic [CHAR_W-1:0]   out_6_o,
  output logic [CHAR_W-1:0]   out_7_o,
  output logic [CHAR_W-1:0]   out_8_o
);

  logic [NUM_BITS:0]                          vld;
  logic [NUM_BITS:0]                          rdy;
  b40cc_ctl_t [NUM_BITS:0]                    ctl;
  logic [NUM_BITS:0][MAX_CHARS-1:0][DIG_W-1:0] dig;
  logic [NUM_BITS:0][NUM_BITS-1:0]            bin;

  logic [MAX_CHARS-1:0][DIG_W-1:0]   dig_ld;
  b40cc_ctl_t                        ctl_ld;
  logic [NUM_BITS-1:0]               bin_ld;

  logic [MAX_DIGITS-1:0][CHAR_W-1:0] ch_in;
  logic [MAX_DIGITS-1:0][CHAR_W-1:0] chars_d, chars_q;
  logic [NUM_BITS-1:0]               code_d, code_q;
  logic                              status_d, status_q;
  logic                              out_valid_q;

  assign ch_in = {char_8_i, char_7_i, char_6_i, char_5_i, char_4_i,
                  char_3_i, char_2_i, char_1_i, char_0_i};

  // load digits up to the first NUL, or the code for a decode beat
  always_comb begin
    logic live;
    live = 1'b1;
    for (int k = 0; k < MAX_CHARS; k++) begin
      live      = live && (ch_in[k] != ASCII_NUL);
      dig_ld[k] = (live && (kind_i == KIND_ENCODE)) ? b40_digit(ch_in[k]) : DIG_SPACE;
    end
    ctl_ld.kind = b40cc_kind_e'(kind_i);
    ctl_ld.ovf  = (kind_i == KIND_DECODE) && (code_in_i > CODE_LIMIT);
    ctl_ld.hi   = 1'b0;
    bin_ld      = (kind_i == KIND_DECODE) ? code_in_i : '0;
  end

  assign dig[0]     = dig_ld;
  assign ctl[0]     = ctl_ld;
  assign bin[0]     = bin_ld;
  assign vld[0]     = in_valid_i;
  assign in_ready_o = rdy[0];

  for (genvar i = 0; i < NUM_BITS; i++) begin : g_cell
    b40cc_cell #(
      .NDIG (MAX_CHARS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[i]),
      .ready_o (rdy[i]),
      .ctl_i   (ctl[i]),
      .dig_i   (dig[i]),
      .bin_i   (bin[i]),
      .valid_o (vld[i+1]),
      .ready_i (rdy[i+1]),
      .ctl_o   (ctl[i+1]),
      .dig_o   (dig[i+1]),
      .bin_o   (bin[i+1])
    );
  end

  assign rdy[NUM_BITS] = !out_valid_q || out_ready_i;

  // on a decode beat without overflow, show a digit while it or any value above it is nonzero
  always_comb begin
    logic show;
    logic live;
    show    = (ctl[NUM_BITS].kind == KIND_DECODE) && !ctl[NUM_BITS].ovf;
    live    = ctl[NUM_BITS].hi;
    chars_d = '0;
    for (int k = MAX_CHARS - 1; k >= 0; k--) begin
      live = live || (dig[NUM_BITS][k] != DIG_SPACE);
      if (show && live) begin
        chars_d[k] = b40_ascii(dig[NUM_BITS][k]);
      end
    end
    code_d   = (ctl[NUM_BITS].kind == KIND_ENCODE) ? bin[NUM_BITS] : '0;
    status_d = ctl[NUM_BITS].ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy[NUM_BITS]) begin
      out_valid_q <= vld[NUM_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld[NUM_BITS] && rdy[NUM_BITS]) begin
      chars_q  <= chars_d;
      code_q   <= code_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign code_out_o  = code_q;
  assign status_o    = status_q;
  assign out_0_o     = chars_q[0];
  assign out_1_o     = chars_q[1];
  assign out_2_o     = chars_q[2];
  assign out_3_o     = chars_q[3];
  assign out_4_o     = chars_q[4];
  assign out_5_o     = chars_q[5];
  assign out_6_o     = chars_q[6];
  assign out_7_o     = chars_q[7];
  assign out_8_o     = chars_q[8];

`include "assert_macros.svh"

  `B40_ASSERT_IMP(a_ovf_zero, out_valid_o && status_o, (code_out_o == '0) && (out_0_o == '0), "overflow beat carries data")
  `B40_ASSERT_IMP(a_enc_no_chars, out_valid_o && (code_out_o != '0), (out_0_o == '0) && !status_o, "encode beat carries characters")
  `B40_ASSERT_IMP(a_chars_contig, out_valid_o && (out_0_o == '0), out_1_o == '0, "decoded string has a gap")
  `B40_ASSERT_IMP(a_ready_when_empty, !out_valid_o, in_ready_o, "input stalled with empty output")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the base-40 callsign encoder/decoder unit.
module testbench;
  import b40cc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CALLSIGN_LEN = 9;

  typedef struct {
    b40cc_kind_e         kind;
    logic [NUM_BITS-1:0] code;
    logic [CHAR_W-1:0]   ch [CALLSIGN_LEN];
  } callsign_req_t;

  typedef struct {
    logic [NUM_BITS-1:0] code;
    logic                status;
    logic [CHAR_W-1:0]   ch [CALLSIGN_LEN];
  } callsign_rsp_t;

  string symbols = " ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-/.";

  logic clk = 1'b0;
  logic rst_n;

  logic                in_valid;
  logic                in_ready;
  b40cc_kind_e         in_kind;
  logic [NUM_BITS-1:0] in_code;
  logic [CHAR_W-1:0]   in_chars [CALLSIGN_LEN];
  logic                out_valid;
  logic                out_ready;
  logic [NUM_BITS-1:0] out_code;
  logic                out_status;
  logic [CHAR_W-1:0]   out_chars [CALLSIGN_LEN];

  callsign_rsp_t pending_conversions [$];
  int unsigned   error_count = 0;
  bit            src_idle = 1'b1;
  bit            sink_idle = 1'b1;
  int unsigned   sink_hold_cycles = 0;

  always #2 clk = ~clk;

  base40_callsign_codec_unit #(
    .MAX_CHARS(CALLSIGN_LEN)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .kind_i     (in_kind),
    .code_in_i  (in_code),
    .char_0_i   (in_chars[0]),
    .char_1_i   (in_chars[1]),
    .char_2_i   (in_chars[2]),
    .char_3_i   (in_chars[3]),
    .char_4_i   (in_chars[4]),
    .char_5_i   (in_chars[5]),
    .char_6_i   (in_chars[6]),
    .char_7_i   (in_chars[7]),
    .char_8_i   (in_chars[8]),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .code_out_o (out_code),
    .status_o   (out_status),
    .out_0_o    (out_chars[0]),
    .out_1_o    (out_chars[1]),
    .out_2_o    (out_chars[2]),
    .out_3_o    (out_chars[3]),
    .out_4_o    (out_chars[4]),
    .out_5_o    (out_chars[5]),
    .out_6_o    (out_chars[6]),
    .out_7_o    (out_chars[7]),
    .out_8_o    (out_chars[8])
  );

  function automatic int unsigned symbol_of(input logic [CHAR_W-1:0] c);
    int unsigned d;
    for (d = 0; d < 40; d++) begin
      if (symbols[d] == c) begin
        return d;
      end
    end
    return 0;
  endfunction

  function automatic callsign_rsp_t base40_convert(input callsign_req_t req);
    callsign_rsp_t       rsp;
    int                  len;
    int                  k;
    int                  pos;
    logic [63:0]         acc;
    logic [NUM_BITS-1:0] rest;
    rsp.code = '0;
    rsp.status = 1'b0;
    foreach (rsp.ch[i]) rsp.ch[i] = '0;
    if (req.kind == KIND_ENCODE) begin
      len = 0;
      while (len < CALLSIGN_LEN && req.ch[len] != 8'h00) len++;
      acc = '0;
      for (k = len - 1; k >= 0; k--) acc = acc * 40 + 64'(symbol_of(req.ch[k]));
      rsp.code = acc[NUM_BITS-1:0];
    end else begin
      rest = req.code;
      if (rest > CODE_LIMIT) begin
        rsp.status = 1'b1;
      end else begin
        pos = 0;
        while (rest != 0) begin
          if (pos < CALLSIGN_LEN) begin
            rsp.ch[pos] = symbols[int'(rest % 40)];
            pos++;
          end
          rest = rest / 40;
        end
      end
    end
    return rsp;
  endfunction

  function automatic callsign_req_t enc_req(input string s, input logic [NUM_BITS-1:0] junk);
    callsign_req_t req;
    req.kind = KIND_ENCODE;
    req.code = junk;
    foreach (req.ch[k]) req.ch[k] = (k < s.len()) ? s[k] : 8'h00;
    return req;
  endfunction

  function automatic callsign_req_t dec_req(input logic [NUM_BITS-1:0] code,
                                            input logic [CHAR_W-1:0] junk);
    callsign_req_t req;
    req.kind = KIND_DECODE;
    req.code = code;
    foreach (req.ch[k]) req.ch[k] = junk;
    return req;
  endfunction

  function automatic callsign_req_t random_request();
    callsign_req_t req;
    int unsigned   mode;
    int unsigned   len;
    int unsigned   k;
    req.code = NUM_BITS'({$urandom(), $urandom()});
    foreach (req.ch[i]) req.ch[i] = CHAR_W'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 0) begin
      req.kind = KIND_ENCODE;
      mode = $urandom_range(0, 3);
      if (mode != 0) begin
        len = $urandom_range(0, CALLSIGN_LEN);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 7) == 0) req.ch[k] = CHAR_W'($urandom_range(1, 255));
          else req.ch[k] = symbols[$urandom_range(0, 39)];
        end
        if (len < CALLSIGN_LEN) req.ch[len] = 8'h00;
      end
    end else begin
      req.kind = KIND_DECODE;
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
        len = $urandom_range(0, CALLSIGN_LEN);
        req.code = '0;
        for (k = 0; k < len; k++) req.code = req.code * 40 + NUM_BITS'($urandom_range(0, 39));
      end else if (mode == 6) begin
        req.code = CODE_LIMIT - NUM_BITS'($urandom_range(0, 1000));
      end else if (mode == 7) begin
        req.code = CODE_LIMIT + 1 + NUM_BITS'($urandom_range(0, 1000));
      end
    end
    return req;
  endfunction

  task automatic send_beat(input callsign_req_t req);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= req.kind;
    in_code <= req.code;
    foreach (in_chars[k]) in_chars[k] <= req.ch[k];
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_conversions.push_back(base40_convert(req));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_conversions.size() != 0);
  endtask

  task automatic test_directed();
    callsign_req_t req;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    send_beat(enc_req("", '1));
    send_beat(enc_req("A", '0));
    send_beat(enc_req("M17-XYZ/Z", 48'hA5A5_5A5A_A5A5));
    send_beat(enc_req(".........", '1));
    send_beat(enc_req("999999999", '0));
    req = enc_req("", '0);
    foreach (req.ch[k]) req.ch[k] = 8'hFF;
    send_beat(req);
    send_beat(enc_req("ab c", '1));
    req = enc_req("ABXCDEFGH", '0);
    req.ch[2] = 8'h00;
    send_beat(req);
    send_beat(enc_req(" A", '0));
    send_beat(enc_req("0-/.Z", '1));
    send_beat(enc_req("@[`{:,+!~", '0));
    send_beat(dec_req('0, 8'hFF));
    send_beat(dec_req(48'd1, 8'h00));
    send_beat(dec_req(48'd39, 8'hFF));
    send_beat(dec_req(48'd40, 8'h41));
    send_beat(dec_req(CODE_LIMIT, 8'h00));
    send_beat(dec_req(CODE_LIMIT + 1, 8'hFF));
    send_beat(dec_req('1, 8'h55));
    send_beat(dec_req(48'h8000_0000_0000, 8'hAA));
    send_beat(dec_req(48'h0000_1234_5678, 8'h00));
  endtask

  task automatic test_streaming(input int unsigned n);
    src_idle = 1'b0;
    sink_idle = 1'b0;
    repeat (n) send_beat(random_request());
  endtask

  task automatic test_backpressure(input int unsigned n);
    src_idle = 1'b0;
    sink_idle = 1'b0;
    sink_hold_cycles = 400;
    repeat (n) send_beat(random_request());
  endtask

  task automatic test_random_idle(input int unsigned n);
    src_idle = 1'b1;
    sink_idle = 1'b1;
    repeat (n) send_beat(random_request());
  endtask

  task automatic check_field(input string name, input logic [NUM_BITS-1:0] want,
                             input logic [NUM_BITS-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    callsign_rsp_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_conversions.size() == 0) begin
        error_count++;
        $display("%0t ns: unexpected result beat, expected none actual code %h",
                 $time, out_code);
      end else begin
        want = pending_conversions.pop_front();
        check_field("code_out", want.code, out_code);
        check_field("status", NUM_BITS'(want.status), NUM_BITS'(out_status));
        foreach (want.ch[k]) begin
          check_field($sformatf("out_%0d", k), NUM_BITS'(want.ch[k]), NUM_BITS'(out_chars[k]));
        end
      end
    end
  end

  initial begin : result_sink
    int unsigned wait_n;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (sink_hold_cycles != 0) begin
        wait_n = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        wait_n = sink_idle ? $urandom_range(0, 9) : 0;
      end
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin : watchdog
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : main
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= KIND_ENCODE;
    in_code <= '0;
    foreach (in_chars[k]) in_chars[k] <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain();
    test_streaming(300);
    drain();
    test_backpressure(150);
    drain();
    test_random_idle(1350);
    drain();
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
